// ----- sv/tesib_pkg.sv -----
// Package for the two-ended sorted insert buffer.
// Holds sizes, request kinds, controller states and the command/status structs.
// Used by tesib_ctrl, tesib_dp and the top level.
package tesib_pkg;

    localparam int DEPTH   = 32;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW      = $clog2(DEPTH + 1);
    localparam int MAX_RES = 32;
    localparam int CAP     = (MAX_RES < DEPTH) ? MAX_RES : DEPTH;
    localparam int KEY_W   = 16;
    localparam int HDL_W   = 8;
    localparam int ENT_W   = KEY_W + HDL_W;
    localparam int SLOT_W  = 6;
    localparam int START_W = 5;
    localparam int KIND_W  = 2;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;

    localparam logic [PW-1:0] DEPTH_P   = PW'(DEPTH);
    localparam logic [PW-1:0] CAP_P     = PW'(CAP);
    localparam logic [PW-1:0] START_RST = PW'((16 >= DEPTH) ? DEPTH - 1 : 16);
    localparam logic [START_W-1:0] START_CFG_RST = START_W'(16);

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_DRAIN   = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_CMP,
        ST_DECIDE,
        ST_SH_RD,
        ST_SH_WR,
        ST_PUT,
        ST_DR_RD,
        ST_DR_OUT,
        ST_DR_EMPTY
    } t_state;

    typedef struct packed {
        logic load_ins;
        logic restart;
        logic load_drain;
        logic srch_rd;
        logic srch_cmp;
        logic decide;
        logic sh_rd;
        logic sh_wr;
        logic put;
        logic dr_rd;
        logic dr_load;
        logic dr_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic srch_more;
        logic shift_more;
        logic win_empty;
        logic out_free;
        logic dr_last;
    } t_dp_sts;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [PW-1:0] v);
        return SLOT_W'(v);
    endfunction

endpackage

// ----- sv/two_ended_sorted_insert_buffer.sv -----
// Top level of the two-ended sorted insert buffer.
// Depends on tesib_pkg, tesib_ctrl, tesib_dp (and tesib_ram through the datapath).
//
// Usage:
//  - Request channel (s_axis_*): tuser selects insert, restart or drain; tdata carries
//    key and handle of an insert. A request is taken only while the buffer is idle.
//  - Result channel (m_axis_*): one result per insert, one per listed entry of a
//    drain (tlast on the final one), a single empty marker for an empty drain.
//    Restart and the unused kind give no result.
//  - i_cfg_we/i_cfg_wdata set the slot where the window restarts.
// Sequence:
//  - Restart and the unused kind are handled in the idle state. Insert: up to
//    log2(depth) + 1 binary search steps (each a registered RAM read and a compare),
//    a placement decision, then one RAM read and one write per entry moved (the shorter
//    side, or up to depth - 1 when an array end blocks it), then the result load.
//  - Drain: per listed entry one RAM read plus one output load; an empty drain
//    loads its empty marker without any RAM read.
// Reset clears the window to the reset start slot; stored entries are left as is.
// When the receiver stalls, the result register holds and the engine waits before
// loading the next result; a new request is taken once the final result is loaded.
module two_ended_sorted_insert_buffer
    import tesib_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [START_W-1:0] i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [IN_W-1:0]    s_axis_tdata,   // [15:0] sort_key, [23:16] entry_handle
    input  logic [KIND_W-1:0]  s_axis_tuser,   // [1:0] kind
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata,   // [7:0] handle, [23:8] key, [29:24] slot,
                                               // [30] dropped, [31] empty_res
    output logic               m_axis_tlast
);

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [HDL_W-1:0]  w_hdl;
    logic [KEY_W-1:0]  w_key;
    logic [SLOT_W-1:0] w_slot;
    logic              w_drop, w_empty;

    tesib_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_kind     (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tesib_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_key        (s_axis_tdata[KEY_W-1:0]),
        .i_hdl        (s_axis_tdata[KEY_W+HDL_W-1:KEY_W]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_m_tready   (m_axis_tready),
        .o_m_tvalid   (m_axis_tvalid),
        .o_out_handle (w_hdl),
        .o_out_key    (w_key),
        .o_slot       (w_slot),
        .o_dropped    (w_drop),
        .o_empty_res  (w_empty),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {w_empty, w_drop, w_slot, w_key, w_hdl};

endmodule

// ----- sv/tesib_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; width and depth are set by parameters.
module tesib_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic                                i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                        o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tesib_ctrl.sv -----
// Controller FSM of the sorted insert buffer: sequences search, shift, put and drain.
// Depends on tesib_pkg; drives tesib_dp through t_dp_cmd and reads t_dp_sts.
module tesib_ctrl
    import tesib_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic [KIND_W-1:0] i_kind,
    output logic        o_s_tready,
    input  t_dp_sts     i_sts,
    output t_dp_cmd     o_cmd
);

    t_state r_state;
    t_state n_state;
    t_kind  w_kind;

    assign w_kind = t_kind'(i_kind);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    case (w_kind)
                        KIND_INSERT: begin
                            o_cmd.load_ins = 1'b1;
                            n_state        = ST_SRCH;
                        end
                        KIND_RESTART: begin
                            o_cmd.restart = 1'b1;
                        end
                        KIND_DRAIN: begin
                            o_cmd.load_drain = 1'b1;
                            n_state = i_sts.win_empty ? ST_DR_EMPTY : ST_DR_RD;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SRCH: begin
                if (i_sts.srch_more) begin
                    o_cmd.srch_rd = 1'b1;
                    n_state       = ST_CMP;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_CMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = ST_SRCH;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = ST_SH_RD;
            end
            ST_SH_RD: begin
                if (i_sts.shift_more) begin
                    o_cmd.sh_rd = 1'b1;
                    n_state     = ST_SH_WR;
                end else begin
                    n_state = ST_PUT;
                end
            end
            ST_SH_WR: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = ST_SH_RD;
            end
            ST_PUT: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_DR_RD: begin
                o_cmd.dr_rd = 1'b1;
                n_state     = ST_DR_OUT;
            end
            ST_DR_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.dr_load = 1'b1;
                    n_state       = i_sts.dr_last ? ST_IDLE : ST_DR_RD;
                end
            end
            ST_DR_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.dr_empty = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/tesib_dp.sv -----
// Datapath of the sorted insert buffer: window pointers, search bounds, entry RAM
// and the result register. Depends on tesib_pkg and tesib_ram; steered by tesib_ctrl.
module tesib_dp
    import tesib_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [START_W-1:0] i_cfg_wdata,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [HDL_W-1:0]   i_hdl,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output logic [HDL_W-1:0]   o_out_handle,
    output logic [KEY_W-1:0]   o_out_key,
    output logic [SLOT_W-1:0]  o_slot,
    output logic               o_dropped,
    output logic               o_empty_res,
    output logic               o_last
);

    logic [START_W-1:0] r_start;
    logic [PW-1:0]      r_wl, r_wr, r_lo, r_hi, r_mid, r_ptr, r_end;
    logic               r_left, r_drop;
    logic [KEY_W-1:0]   r_key;
    logic [HDL_W-1:0]   r_hdl;

    logic               r_mvalid;
    logic [HDL_W-1:0]   r_o_hdl;
    logic [KEY_W-1:0]   r_o_key;
    logic [SLOT_W-1:0]  r_o_slot;
    logic               r_o_drop, r_o_empty, r_o_last;

    logic [PW-1:0]      w_mid, w_clamp, w_wr_eff, w_lc, w_rc, w_n, w_put_slot, w_ptr_inc;
    logic               w_noleft, w_norite, w_full, w_drop, w_append, w_go_left;
    logic               w_win_empty, w_out_free, w_load;
    logic               w_we, w_re;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [ENT_W-1:0]   w_wdata, w_rdata;
    logic [KEY_W-1:0]   w_rd_key;
    logic [HDL_W-1:0]   w_rd_hdl;

    assign w_rd_key = w_rdata[KEY_W-1:0];
    assign w_rd_hdl = w_rdata[ENT_W-1:KEY_W];

    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_clamp     = (int'(r_start) >= DEPTH) ? PW'(DEPTH - 1) : PW'(r_start);
    assign w_win_empty = (r_wl == r_wr);
    assign w_n         = r_wr - r_wl;
    assign w_ptr_inc   = r_ptr + PW'(1);

    // placement decision, with r_lo as the insertion index
    assign w_noleft  = (r_wl == '0);
    assign w_norite  = (r_wr >= DEPTH_P);
    assign w_full    = w_noleft && w_norite;
    assign w_drop    = w_full && (r_lo >= r_wr);
    assign w_wr_eff  = w_full ? (r_wr - PW'(1)) : r_wr;
    assign w_append  = !w_norite && (r_lo == r_wr);
    assign w_lc      = r_lo - r_wl;
    assign w_rc      = w_wr_eff - r_lo;
    assign w_go_left = !w_append && !w_noleft &&
                       ((r_lo == r_wl) || w_norite || (w_lc <= w_rc));

    assign w_put_slot = r_left ? (r_lo - PW'(1)) : r_lo;

    assign w_out_free = !r_mvalid || i_m_tready;
    assign w_load     = i_cmd.put || i_cmd.dr_load || i_cmd.dr_empty;

    assign o_sts.srch_more  = (r_lo < r_hi);
    assign o_sts.shift_more = !r_drop && (r_left ? (r_ptr < r_lo) : (r_ptr > r_lo));
    assign o_sts.win_empty  = w_win_empty;
    assign o_sts.out_free   = w_out_free;
    assign o_sts.dr_last    = (w_ptr_inc == r_end);

    // RAM port steering
    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_ptr[AW-1:0];
        if (i_cmd.srch_rd) begin
            w_re    = 1'b1;
            w_raddr = w_mid[AW-1:0];
        end else if (i_cmd.sh_rd) begin
            w_re    = 1'b1;
            w_raddr = r_left ? r_ptr[AW-1:0] : (r_ptr[AW-1:0] - AW'(1));
        end else if (i_cmd.dr_rd) begin
            w_re = 1'b1;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_put_slot[AW-1:0];
        w_wdata = {r_hdl, r_key};
        if (i_cmd.sh_wr) begin
            w_we    = 1'b1;
            w_waddr = r_left ? (r_ptr[AW-1:0] - AW'(1)) : r_ptr[AW-1:0];
            w_wdata = w_rdata;
        end else if (i_cmd.put && !r_drop) begin
            w_we = 1'b1;
        end
    end

    tesib_ram #(
        .W (ENT_W),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // control state: start slot, window and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= START_CFG_RST;
            r_wl     <= START_RST;
            r_wr     <= START_RST;
            r_mvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
            if (i_cmd.restart) begin
                r_wl <= w_clamp;
                r_wr <= w_clamp;
            end else if (i_cmd.decide) begin
                if (!w_drop) begin
                    r_wr <= w_wr_eff;
                end
            end else if (i_cmd.put && !r_drop) begin
                if (r_left) begin
                    r_wl <= r_wl - PW'(1);
                end else begin
                    r_wr <= r_wr + PW'(1);
                end
            end
            if (w_load) begin
                r_mvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // working registers of the current request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ins) begin
            r_key <= i_key;
            r_hdl <= i_hdl;
            r_lo  <= r_wl;
            r_hi  <= r_wr;
        end
        if (i_cmd.srch_rd) begin
            r_mid <= w_mid;
        end
        if (i_cmd.srch_cmp) begin
            if (r_key < w_rd_key) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid + PW'(1);
            end
        end
        if (i_cmd.decide) begin
            r_drop <= w_drop;
            r_left <= w_go_left;
            r_ptr  <= w_go_left ? r_wl : w_wr_eff;
        end
        if (i_cmd.sh_wr) begin
            r_ptr <= r_left ? w_ptr_inc : (r_ptr - PW'(1));
        end
        if (i_cmd.load_drain) begin
            r_ptr <= r_wl;
            r_end <= r_wl + ((w_n > CAP_P) ? CAP_P : w_n);
        end
        if (i_cmd.dr_load) begin
            r_ptr <= w_ptr_inc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_o_hdl   <= r_hdl;
            r_o_key   <= r_key;
            r_o_slot  <= r_drop ? to_slot(DEPTH_P) : to_slot(w_put_slot);
            r_o_drop  <= r_drop;
            r_o_empty <= 1'b0;
            r_o_last  <= 1'b1;
        end else if (i_cmd.dr_load) begin
            r_o_hdl   <= w_rd_hdl;
            r_o_key   <= w_rd_key;
            r_o_slot  <= to_slot(r_ptr);
            r_o_drop  <= 1'b0;
            r_o_empty <= 1'b0;
            r_o_last  <= (w_ptr_inc == r_end);
        end else if (i_cmd.dr_empty) begin
            r_o_hdl   <= '0;
            r_o_key   <= '0;
            r_o_slot  <= to_slot(r_wl);
            r_o_drop  <= 1'b0;
            r_o_empty <= 1'b1;
            r_o_last  <= 1'b1;
        end
    end

    assign o_m_tvalid   = r_mvalid;
    assign o_out_handle = r_o_hdl;
    assign o_out_key    = r_o_key;
    assign o_slot       = r_o_slot;
    assign o_dropped    = r_o_drop;
    assign o_empty_res  = r_o_empty;
    assign o_last       = r_o_last;

    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wl <= r_wr)
        else $error("window left edge passed right edge");

    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr <= DEPTH_P)
        else $error("window right edge beyond array");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.srch_cmp |-> (r_lo < r_hi))
        else $error("search compare with empty range");

    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put && !r_drop) |=>
        ((r_wr - r_wl) == ($past(r_wr - r_wl) + PW'(1))))
        else $error("insert did not grow window by one");

endmodule

// ----- verif/tesib_checker.sv -----
// Checker for the two-ended sorted insert buffer: watches the request, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on tesib_pkg for sizes and request kinds.
module tesib_checker
    import tesib_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [START_W-1:0] i_cfg_wdata,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [IN_W-1:0]    i_req_data,
    input  logic [KIND_W-1:0]  i_req_user,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [OUT_W-1:0]   i_res_data,
    input  logic               i_res_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_matched
);

    typedef struct packed {
        logic [HDL_W-1:0]  hdl;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
        logic              dropped;
        logic              empty;
        logic              last;
    } t_result;

    logic [KEY_W-1:0]   key_mem [DEPTH];
    logic [HDL_W-1:0]   hdl_mem [DEPTH];
    logic [START_W-1:0] start_reg;
    int                 win_lo;
    int                 win_hi;
    t_result            due_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_matched    = 0;
    end

    function automatic int start_pos();
        return (int'(start_reg) >= DEPTH) ? DEPTH - 1 : int'(start_reg);
    endfunction

    function automatic void store(int s, logic [KEY_W-1:0] key, logic [HDL_W-1:0] hdl);
        if (s >= 0 && s < DEPTH) begin
            key_mem[s] = key;
            hdl_mem[s] = hdl;
        end
    endfunction

    function automatic void owe(logic [HDL_W-1:0] hdl, logic [KEY_W-1:0] key, int slot,
                                logic dropped, logic empty, logic last);
        t_result r;
        r.hdl     = hdl;
        r.key     = key;
        r.slot    = SLOT_W'(slot);
        r.dropped = dropped;
        r.empty   = empty;
        r.last    = last;
        due_q.push_back(r);
    endfunction

    // Returns the slot written, or DEPTH when the entry is dropped.
    function automatic int place_entry(logic [KEY_W-1:0] key, logic [HDL_W-1:0] hdl);
        int lo;
        int hi;
        int mid;
        int idx;
        int lc;
        int rc;
        int i;
        bit noleft;
        bit norite;
        bit go_left;
        if (win_lo == win_hi) begin
            store(win_lo, key, hdl);
            win_hi++;
            return win_lo;
        end
        noleft = (win_lo == 0);
        norite = (win_hi >= DEPTH);
        lo = win_lo;
        hi = win_hi;
        // upper bound: equal keys land after the existing ones
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (mid < DEPTH && key < key_mem[mid])
                hi = mid;
            else
                lo = mid + 1;
        end
        idx = lo;
        if (noleft && norite) begin
            if (idx >= win_hi)
                return DEPTH;
            // drop the last entry to make room
            win_hi--;
            norite = 0;
        end else if (!norite && idx == win_hi) begin
            store(idx, key, hdl);
            win_hi++;
            return idx;
        end else if (!noleft && idx == win_lo) begin
            win_lo--;
            store(idx - 1, key, hdl);
            return idx - 1;
        end
        lc = idx - win_lo;
        rc = win_hi - idx;
        go_left = norite || (lc <= rc && !noleft);
        if (go_left) begin
            for (i = win_lo; i < idx; i++)
                store(i - 1, key_mem[i], hdl_mem[i]);
            win_lo--;
            store(idx - 1, key, hdl);
            return idx - 1;
        end
        for (i = win_hi; i > idx; i--)
            store(i, key_mem[i - 1], hdl_mem[i - 1]);
        win_hi++;
        store(idx, key, hdl);
        return idx;
    endfunction

    function automatic void buffer_step(t_kind kind, logic [KEY_W-1:0] key,
                                        logic [HDL_W-1:0] hdl);
        int s;
        int n;
        int k;
        case (kind)
            KIND_INSERT: begin
                s = place_entry(key, hdl);
                owe(hdl, key, s, s >= DEPTH, 1'b0, 1'b1);
            end
            KIND_RESTART: begin
                win_lo = start_pos();
                win_hi = win_lo;
            end
            KIND_DRAIN: begin
                n = win_hi - win_lo;
                if (n == 0) begin
                    owe('0, '0, win_lo, 1'b0, 1'b1, 1'b1);
                end else begin
                    if (n > MAX_RES)
                        n = MAX_RES;
                    for (k = 0; k < n; k++) begin
                        s = win_lo + k;
                        if (s < DEPTH)
                            owe(hdl_mem[s], key_mem[s], s, 1'b0, 1'b0, k + 1 == n);
                        else
                            owe('0, '0, s, 1'b0, 1'b0, k + 1 == n);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void note_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    function automatic void check_result(logic [OUT_W-1:0] data, logic last);
        t_result want;
        int      fails_before;
        if (due_q.size() == 0) begin
            $display("%0t: result with nothing due, expected none, got data 0x%08h last %0b",
                     $time, data, last);
            o_fail_count++;
            return;
        end
        want = due_q.pop_front();
        fails_before = o_fail_count;
        note_field("handle", want.hdl, data[7:0]);
        note_field("key", want.key, data[23:8]);
        note_field("slot", want.slot, data[29:24]);
        note_field("dropped", want.dropped, data[30]);
        note_field("empty", want.empty, data[31]);
        note_field("last", want.last, last);
        if (o_fail_count == fails_before)
            o_matched++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_reg = START_CFG_RST;
            win_lo    = int'(START_RST);
            win_hi    = win_lo;
            for (int i = 0; i < DEPTH; i++) begin
                key_mem[i] = '0;
                hdl_mem[i] = '0;
            end
            due_q.delete();
        end else begin
            if (i_cfg_we)
                start_reg = i_cfg_wdata;
            if (i_res_valid && i_res_ready)
                check_result(i_res_data, i_res_last);
            if (i_req_valid && i_req_ready)
                buffer_step(t_kind'(i_req_user), i_req_data[15:0], i_req_data[23:16]);
        end
        o_pending <= due_q.size();
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the two-ended sorted insert buffer: drives requests, start-slot
// writes and result back-pressure, and gives the verdict.
// Depends on tesib_pkg, two_ended_sorted_insert_buffer and tesib_checker.
module tb
    import tesib_pkg::*;
();

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [START_W-1:0] i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata  = '0;
    logic [KIND_W-1:0]  s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tlast;

    int fail_count;
    int pending;
    int matched;
    int sent     = 0;
    int settings = 0;
    int rx_hold  = 0;
    bit steady   = 1'b0;

    always #2 i_clk = ~i_clk;

    two_ended_sorted_insert_buffer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    tesib_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_matched    (matched)
    );

    // mostly back to back or short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // extremes and a narrow range for duplicates, otherwise any key
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5)
            return KEY_W'($urandom_range(0, 7));
        return KEY_W'($urandom);
    endfunction

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else if (steady || !m_axis_tready) begin
            m_axis_tready <= 1'b1;
            rx_hold <= steady ? 0 : $urandom_range(0, 8);
        end else begin
            m_axis_tready <= 1'b0;
            rx_hold <= gap_len();
        end
    end

    task automatic send_request(t_kind kind, logic [KEY_W-1:0] key, logic [HDL_W-1:0] hdl);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {hdl, key};
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind != KIND_NONE)
            sent++;
    endtask

    // Hold off until every due result is in and the engine has gone quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_start(logic [START_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings++;
    endtask

    initial begin
        int phase;
        int n;
        int r;
        int waited;
        logic [START_W-1:0] start;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty drain, extremes, equal keys, ignored kind
        send_request(KIND_DRAIN, '0, '0);
        send_request(KIND_INSERT, 16'hFFFF, 8'hFF);
        send_request(KIND_INSERT, 16'h0000, 8'h00);
        send_request(KIND_INSERT, 16'hFFFF, 8'hAA);
        send_request(KIND_INSERT, 16'h8000, 8'h55);
        send_request(KIND_NONE, 16'hFFFF, 8'hFF);
        send_request(KIND_DRAIN, '0, '0);
        send_request(KIND_RESTART, 16'hFFFF, 8'hFF);
        send_request(KIND_DRAIN, '0, '0);
        // left end blocked: shift right
        set_start('0);
        send_request(KIND_RESTART, '0, '0);
        send_request(KIND_INSERT, 16'd100, 8'd1);
        send_request(KIND_INSERT, 16'd50, 8'd2);
        send_request(KIND_INSERT, 16'd200, 8'd3);
        send_request(KIND_DRAIN, '0, '0);
        // right end blocked: shift left
        set_start('1);
        send_request(KIND_RESTART, '0, '0);
        send_request(KIND_INSERT, 16'd100, 8'd4);
        send_request(KIND_INSERT, 16'd300, 8'd5);
        send_request(KIND_INSERT, 16'd200, 8'd6);
        send_request(KIND_DRAIN, '0, '0);

        phase = 0;
        while (sent < 480) begin
            case (phase)
                0:       start = '0;
                1:       start = '1;
                2:       start = START_W'(16);
                default: start = START_W'($urandom_range(0, 31));
            endcase
            set_start(start);
            steady <= ($urandom_range(0, 3) == 0);
            if (phase < 3 || $urandom_range(0, 3) != 0)
                send_request(KIND_RESTART, KEY_W'($urandom), HDL_W'($urandom));
            n = (phase < 2) ? 40 : $urandom_range(3, 45);
            for (int j = 0; j < n; j++) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_request(KIND_DRAIN, KEY_W'($urandom), HDL_W'($urandom));
                else if (r < 12)
                    send_request(KIND_NONE, KEY_W'($urandom), HDL_W'($urandom));
                else if (r < 14)
                    send_request(KIND_RESTART, KEY_W'($urandom), HDL_W'($urandom));
                else
                    send_request(KIND_INSERT, pick_key(), HDL_W'($urandom));
            end
            send_request(KIND_DRAIN, KEY_W'($urandom), HDL_W'($urandom));
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        for (waited = 0; waited < 200000 && pending != 0; waited++)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("covered %0d requests over %0d start-slot settings (empty, full, overflow)",
                 sent, settings);
        $display("%0d results matched, %0d mismatches, %0d still due",
                 matched, fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- two_ended_sorted_insert_buffer.f -----
sv/tesib_pkg.sv
sv/tesib_ram.sv
sv/tesib_ctrl.sv
sv/tesib_dp.sv
sv/two_ended_sorted_insert_buffer.sv
verif/tesib_checker.sv
verif/tb.sv
